FILE: rtl/whr_pkg.sv
// ----------------------------------------------------------------------------
// whr_pkg: shared types and constants of the wait-hint save/restore table
// Slot count, field widths, the token that walks the cell row, the commit
// command and the bucket function.
// ----------------------------------------------------------------------------
`default_nettype none

package whr_pkg;

  localparam int SLOTS          = 16;
  localparam int BUCKETS        = 5;
  localparam int CAPACITY_SCALE = 1024;
  localparam int BUCKET_DELTA   = (CAPACITY_SCALE + BUCKETS / 2) / BUCKETS;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W     = 23;
  localparam int VAL_W    = 11;
  localparam int BUCKET_W = 5;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GROUP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_VALUE  = 1'b1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_END   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_IGNORED  = 3'd0,
    STAT_HINTED   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RESTORED = 3'd3,
    STAT_NO_HINT  = 3'd4
  } whr_status_t;

  typedef enum logic {
    OP_TAKE = 1'b0,
    OP_FREE = 1'b1
  } whr_op_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              req;
    logic [ID_W-1:0]   tid;
    logic              found;
    logic [SLOT_W-1:0] found_idx;
    logic [VAL_W-1:0]  saved;
    logic              free_seen;
    logic [SLOT_W-1:0] free_idx;
  } whr_tok_t;

  // slot update broadcast at the end of a request
  typedef struct packed {
    logic              valid;
    whr_op_t           op;
    logic [SLOT_W-1:0] idx;
    logic [ID_W-1:0]   tid;
    logic [VAL_W-1:0]  value;
  } whr_cmd_t;

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [VAL_W-1:0] v);
    logic [BUCKET_W-1:0] b;
    b = '0;
    for (int k = 1; k < BUCKETS; k++) begin
      if (32'(v) >= k * BUCKET_DELTA) b = BUCKET_W'(k);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/whr_cell.sv
// ----------------------------------------------------------------------------
// whr_cell: one slot of the table
// Holds a task id and its saved value, marks the passing token with the
// first own-slot hit and the first free slot, and applies commit commands.
// ----------------------------------------------------------------------------
`default_nettype none

module whr_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [whr_pkg::SLOT_W-1:0] my_idx,
  input  wire whr_pkg::whr_tok_t         tok_in,
  input  wire whr_pkg::whr_cmd_t         cmd,
  output whr_pkg::whr_tok_t              tok_out
);

  logic [whr_pkg::ID_W-1:0]  slot_task;
  logic [whr_pkg::VAL_W-1:0] slot_saved;
  whr_pkg::whr_tok_t         tok_next;
  logic                      hit;
  logic                      is_free;

  assign is_free = (slot_task == '0);
  // tid 0 would alias a free slot, so it never hits
  assign hit     = (tok_in.tid != '0) && (slot_task == tok_in.tid);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found && hit) begin
      tok_next.found     = 1'b1;
      tok_next.found_idx = my_idx;
      tok_next.saved     = slot_saved;
    end
    if (!tok_in.free_seen && is_free) begin
      tok_next.free_seen = 1'b1;
      tok_next.free_idx  = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_task <= '0;
    end else if (cmd.valid && cmd.idx == my_idx) begin
      case (cmd.op)
        whr_pkg::OP_TAKE: slot_task <= cmd.tid;
        whr_pkg::OP_FREE: slot_task <= '0;
        default:          slot_task <= slot_task;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.idx == my_idx && cmd.op == whr_pkg::OP_TAKE) begin
      slot_saved <= cmd.value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wait_hint_save_restore_table_core.sv
// ----------------------------------------------------------------------------
// wait_hint_save_restore_table_core: per-task floor save/restore slot table
// Row of slot cells searched by a token that moves one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one wait event: req_type,
//   task_id, group_id, current_value. Output channel (out_valid/out_stall)
//   returns exactly one result per event: write_back, new_value, new_bucket,
//   status and the running hinted_total.
//   Config port (cfg_valid/cfg_ready, always ready) writes target_group
//   (index 0) or floor_value (index 1); write only while no request is open.
//   Each request walks its token through the SLOTS cells one per cycle; the
//   token is then captured in the hold register and the result is committed
//   once the output register is free. One request is in flight at a time
//   and in_stall stays high until it commits.
//   A finished result sits in the output register while the next request is
//   accepted; a commit waits only if that register is still stalled.
//   Reset frees all slots, clears the hint count, sets target_group to 0
//   and floor_value to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module wait_hint_save_restore_table_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          req_type,
  input  wire logic [whr_pkg::ID_W-1:0]      task_id,
  input  wire logic [whr_pkg::ID_W-1:0]      group_id,
  input  wire logic [whr_pkg::VAL_W-1:0]     current_value,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          write_back,
  output      logic [whr_pkg::VAL_W-1:0]     new_value,
  output      logic [whr_pkg::BUCKET_W-1:0]  new_bucket,
  output      logic [whr_pkg::STAT_W-1:0]    status,
  output      logic [whr_pkg::COUNT_W-1:0]   hinted_total,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [whr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [whr_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [whr_pkg::ID_W-1:0]    target_group;
  logic [whr_pkg::VAL_W-1:0]   floor_value;
  logic [whr_pkg::COUNT_W-1:0] hint_count;
  logic [whr_pkg::ID_W-1:0]    req_group;
  logic [whr_pkg::VAL_W-1:0]   req_value;

  whr_pkg::whr_tok_t tok [whr_pkg::SLOTS+1];
  whr_pkg::whr_tok_t hold;
  whr_pkg::whr_cmd_t cmd;
  logic [whr_pkg::SLOTS:0] tok_active;

  logic                         in_accept;
  logic                         out_free;
  logic                         commit;
  logic                         res_wb;
  logic [whr_pkg::VAL_W-1:0]    res_value;
  whr_pkg::whr_status_t         res_status;
  logic                         res_hint;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign commit    = (state == ST_COMMIT) && out_free;
  assign cfg_ready = 1'b1;

  // token injected at cell 0 on the accepting edge
  always_comb begin
    tok[0]           = '0;
    tok[0].active    = in_accept;
    tok[0].req       = req_type;
    tok[0].tid       = task_id;
  end

  for (genvar i = 0; i < whr_pkg::SLOTS; i++) begin : g_cell
    whr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (whr_pkg::SLOT_W'(i)),
      .tok_in  (tok[i]),
      .cmd     (cmd),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= whr_pkg::SLOTS; i++) begin
      tok_active[i] = tok[i].active;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_SCAN;
      ST_SCAN:   if (tok[whr_pkg::SLOTS].active) state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_group <= group_id;
      req_value <= current_value;
    end
    if (state == ST_SCAN && tok[whr_pkg::SLOTS].active) begin
      hold <= tok[whr_pkg::SLOTS];
    end
  end

  // decide the outcome from the token that walked the whole row
  always_comb begin
    cmd        = '0;
    res_wb     = 1'b0;
    res_value  = '0;
    res_status = whr_pkg::STAT_IGNORED;
    res_hint   = 1'b0;
    if (hold.tid != '0 && hold.req == whr_pkg::REQ_START) begin
      if (target_group != '0 && req_group == target_group) begin
        if (hold.found || hold.free_seen) begin
          cmd.valid  = commit;
          cmd.op     = whr_pkg::OP_TAKE;
          cmd.idx    = hold.found ? hold.found_idx : hold.free_idx;
          cmd.tid    = hold.tid;
          cmd.value  = req_value;
          res_wb     = 1'b1;
          res_value  = floor_value;
          res_status = whr_pkg::STAT_HINTED;
          res_hint   = 1'b1;
        end else begin
          res_status = whr_pkg::STAT_FULL;
        end
      end
    end else if (hold.tid != '0) begin
      if (hold.found) begin
        cmd.valid  = commit;
        cmd.op     = whr_pkg::OP_FREE;
        cmd.idx    = hold.found_idx;
        cmd.tid    = hold.tid;
        res_wb     = 1'b1;
        res_value  = hold.saved;
        res_status = whr_pkg::STAT_RESTORED;
      end else begin
        res_status = whr_pkg::STAT_NO_HINT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      write_back <= res_wb;
      new_value  <= res_value;
      new_bucket <= res_wb ? whr_pkg::bucket_of(res_value) : '0;
      status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint_count <= '0;
    end else if (commit && res_hint) begin
      hint_count <= hint_count + 1'b1;
    end
  end

  // count only moves on the edge that loads its result, so it stays aligned
  assign hinted_total = hint_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_group <= '0;
      floor_value  <= whr_pkg::VAL_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        whr_pkg::CFG_TARGET_GROUP: target_group <= cfg_data;
        whr_pkg::CFG_FLOOR_VALUE:  floor_value  <= cfg_data[whr_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_active[whr_pkg::SLOTS:1]) <= 1)
    else $error("more than one token in the cell row");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (tok_active[whr_pkg::SLOTS:1] == '0))
    else $error("request accepted while a search is running");

  a_wb_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_back) |->
      (status == whr_pkg::STAT_HINTED || status == whr_pkg::STAT_RESTORED))
    else $error("write-back with a non-updating status");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (hint_count != $past(hint_count)) |->
      (out_valid && status == whr_pkg::STAT_HINTED &&
       hint_count == $past(hint_count) + 1'b1))
    else $error("hint count moved without a hint");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && out_valid) |-> !out_stall)
    else $error("commit over a stalled result");

endmodule

`default_nettype wire
